// ===== rtl/sorted_timer_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_timer_queue_macros: assertion helpers
// Concurrent check macros; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define STQ_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in a cycle implies condition in the next
`define STQ_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants
// Word layouts, result kinds and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package stq_pkg;

  // default sizing
  localparam int STQ_DEPTH   = 16;
  localparam int STQ_ID_BITS = 16;

  // fixed field widths
  localparam int TIME_W     = 32;
  localparam int ARG_W      = 32;
  localparam int ACT_W      = 4;
  localparam int TIMER_ID_W = 16;

  // input modes
  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_FIRED     = 3'd1;
  localparam logic [2:0] KIND_CANCEL_OK = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;
  localparam logic [2:0] KIND_NONE_DUE  = 3'd5;

  typedef struct packed {
    logic [1:0]              mode;
    logic [TIME_W-1:0]       current_time;
    logic signed [31:0]      delay_seconds;
    logic [ACT_W-1:0]        action_code;
    logic [ARG_W-1:0]        argument_handle;
    logic [TIMER_ID_W-1:0]   cancel_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [TIMER_ID_W-1:0]   timer_id;
    logic [ACT_W-1:0]        fired_action;
    logic [ARG_W-1:0]        fired_argument;
    logic                    id_overrun;
    logic                    last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the accepted word
    logic proc;    // table read data valid, process it
    logic finish;  // commit and report
    logic rd_en;   // table read
  } stq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk;      // the table must be walked
    logic down;      // walk from tail toward head
    logic walk_end;  // current entry is the last one to visit
  } stq_sts_t;

endpackage

// ===== rtl/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl: sequencer
// Steps each word through load, setup, table walk and finish, and issues
// a table read in setup when a walk follows and in each walk cycle but the last.
// ----------------------------------------------------------------------------
module stq_ctrl
  import stq_pkg::*;
#(
  parameter int DEPTH = STQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  stq_sts_t                   sts,
  input  logic [$clog2(DEPTH)-1:0]   first_idx,
  output stq_cmd_t                   cmd,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [$clog2(DEPTH)-1:0]   dat_idx
);

  localparam int IDXW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SETUP  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [IDXW-1:0] dat_idx_r, dat_idx_nxt;

  // next state and commands
  always_comb begin
    cmd         = '0;
    rd_addr     = dat_idx_r;
    dat_idx_nxt = dat_idx_r;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts.walk) begin
          cmd.rd_en   = 1'b1;
          rd_addr     = first_idx;
          dat_idx_nxt = first_idx;
          state_nxt   = S_WALK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.proc = 1'b1;
        if (sts.walk_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          rd_addr     = sts.down ? dat_idx_r - IDXW'(1) : dat_idx_r + IDXW'(1);
          dat_idx_nxt = rd_addr;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // index of the entry whose read data is now in the read register
  always_ff @(posedge clk) begin
    dat_idx_r <= dat_idx_nxt;
  end

  assign busy    = (state_r != S_IDLE);
  assign dat_idx = dat_idx_r;

endmodule

// ===== rtl/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// stq_datapath: timer table and result logic
// Holds the sorted table in a memory with one read and one write port,
// shifts entries during the walk and builds result words into the output
// register.
// ----------------------------------------------------------------------------
module stq_datapath
  import stq_pkg::*;
#(
  parameter int DEPTH   = STQ_DEPTH,
  parameter int ID_BITS = STQ_ID_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  in_word_t                   in_word,
  input  stq_cmd_t                   cmd,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [$clog2(DEPTH)-1:0]   dat_idx,
  output stq_sts_t                   sts,
  output logic [$clog2(DEPTH)-1:0]   first_idx,
  output logic                       out_valid,
  output out_word_t                  out_word
);

  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CMPW = (ID_BITS > TIMER_ID_W) ? ID_BITS : TIMER_ID_W;

  // internal operation codes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_IMM    = 3'd1;
  localparam logic [2:0] OP_FULL   = 3'd2;
  localparam logic [2:0] OP_INS    = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // table memory
  logic [TIME_W-1:0]  mem_exp [DEPTH];
  logic [ID_BITS-1:0] mem_id  [DEPTH];
  logic [ACT_W-1:0]   mem_act [DEPTH];
  logic [ARG_W-1:0]   mem_arg [DEPTH];

  logic [TIME_W-1:0]  rd_exp_r;
  logic [ID_BITS-1:0] rd_id_r;
  logic [ACT_W-1:0]   rd_act_r;
  logic [ARG_W-1:0]   rd_arg_r;

  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic [TIME_W-1:0]  wr_exp;
  logic [ID_BITS-1:0] wr_id;
  logic [ACT_W-1:0]   wr_act;
  logic [ARG_W-1:0]   wr_arg;

  // per-word registers
  logic [2:0]            op_r;
  logic [TIME_W-1:0]     now_r;
  logic [TIME_W-1:0]     exp_r;
  logic [ACT_W-1:0]      act_r;
  logic [ARG_W-1:0]      arg_r;
  logic [TIMER_ID_W-1:0] cid_r;
  logic [ID_BITS-1:0]    id_new_r;
  logic                  ovr_r;
  logic [IDXW-1:0]       ins_pos_r;

  // persistent and walk state
  logic [CNTW-1:0]    count_r;
  logic [ID_BITS-1:0] next_id_r;
  logic               found_r;
  logic               stopped_r;
  logic               pend_v_r;
  logic [CNTW-1:0]    k_r;
  out_word_t          pend_r;

  logic               out_valid_r;
  out_word_t          out_word_r;

  logic               emit_v;
  out_word_t          emit_w;

  logic [2:0]         op_in;
  logic [TIME_W:0]    sum_w;
  logic [TIME_W-1:0]  exp_in;
  logic [ID_BITS-1:0] id_inc;
  logic               id_wrap;
  logic [ID_BITS-1:0] id_sel;

  logic [CNTW-1:0]    cnt_m1;
  logic               last_up;
  logic               due;
  logic               later;
  logic               id_hit;
  logic [CMPW-1:0]    rd_id_ext;
  logic [CMPW-1:0]    new_id_ext;

  // classify the incoming word
  always_comb begin
    unique case (in_word.mode)
      MODE_SCHEDULE: begin
        if (in_word.delay_seconds == '0 || in_word.delay_seconds[31]) begin
          op_in = OP_IMM;
        end else if (count_r == CNTW'(DEPTH)) begin
          op_in = OP_FULL;
        end else begin
          op_in = OP_INS;
        end
      end
      MODE_CANCEL: op_in = OP_CANCEL;
      MODE_TICK:   op_in = OP_TICK;
      default:     op_in = OP_NONE;
    endcase
  end

  // saturating expiry and next id
  assign sum_w   = {1'b0, in_word.current_time} + {1'b0, in_word.delay_seconds};
  assign exp_in  = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];
  assign id_inc  = next_id_r + ID_BITS'(1);
  assign id_wrap = (id_inc == '0);
  assign id_sel  = id_wrap ? ID_BITS'(1) : id_inc;

  // walk compares
  assign cnt_m1     = count_r - CNTW'(1);
  assign last_up    = (dat_idx == cnt_m1[IDXW-1:0]);
  assign due        = (rd_exp_r <= now_r);
  assign later      = (rd_exp_r > exp_r);
  assign rd_id_ext  = CMPW'(rd_id_r);
  assign new_id_ext = CMPW'(id_new_r);
  assign id_hit     = (rd_id_ext == CMPW'(cid_r));

  // status to the sequencer
  always_comb begin
    sts.walk  = (count_r != '0) &&
                (op_r == OP_INS || op_r == OP_CANCEL || op_r == OP_TICK);
    sts.down  = (op_r == OP_INS);
    first_idx = (op_r == OP_INS) ? cnt_m1[IDXW-1:0] : '0;
    case (op_r)
      OP_INS:    sts.walk_end = !later || (dat_idx == '0);
      OP_CANCEL: sts.walk_end = last_up;
      OP_TICK:   sts.walk_end = last_up || (!stopped_r && !due && k_r == '0);
      default:   sts.walk_end = 1'b1;
    endcase
  end

  // table writes and result words
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dat_idx;
    wr_exp  = rd_exp_r;
    wr_id   = rd_id_r;
    wr_act  = rd_act_r;
    wr_arg  = rd_arg_r;
    emit_v  = 1'b0;
    emit_w  = '0;
    if (cmd.proc) begin
      case (op_r)
        OP_INS: begin
          // later entry moves one slot toward the tail
          if (later) begin
            wr_en   = 1'b1;
            wr_addr = dat_idx + IDXW'(1);
          end
        end
        OP_CANCEL: begin
          // entries past the match close the gap
          if (found_r) begin
            wr_en   = 1'b1;
            wr_addr = dat_idx - IDXW'(1);
          end
        end
        OP_TICK: begin
          if (stopped_r) begin
            wr_en   = 1'b1;
            wr_addr = dat_idx - k_r[IDXW-1:0];
          end else if (due) begin
            // another due entry: the held one is not the last
            if (pend_v_r) begin
              emit_v      = 1'b1;
              emit_w      = pend_r;
              emit_w.last = 1'b0;
            end
          end else begin
            // first entry not due moves to the head of the remainder
            wr_en   = 1'b1;
            wr_addr = dat_idx - k_r[IDXW-1:0];
            emit_v  = 1'b1;
            if (pend_v_r) begin
              emit_w      = pend_r;
              emit_w.last = 1'b1;
            end else begin
              emit_w.kind = KIND_NONE_DUE;
              emit_w.last = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      case (op_r)
        OP_IMM: begin
          emit_v                = 1'b1;
          emit_w.kind           = KIND_FIRED;
          emit_w.fired_action   = act_r;
          emit_w.fired_argument = arg_r;
          emit_w.last           = 1'b1;
        end
        OP_FULL: begin
          emit_v      = 1'b1;
          emit_w.kind = KIND_FULL;
          emit_w.last = 1'b1;
        end
        OP_INS: begin
          wr_en             = 1'b1;
          wr_addr           = ins_pos_r;
          wr_exp            = exp_r;
          wr_id             = id_new_r;
          wr_act            = act_r;
          wr_arg            = arg_r;
          emit_v            = 1'b1;
          emit_w.kind       = KIND_SCHEDULED;
          emit_w.timer_id   = new_id_ext[TIMER_ID_W-1:0];
          emit_w.id_overrun = ovr_r;
          emit_w.last       = 1'b1;
        end
        OP_CANCEL: begin
          emit_v          = 1'b1;
          emit_w.kind     = found_r ? KIND_CANCEL_OK : KIND_NOT_FOUND;
          emit_w.timer_id = cid_r;
          emit_w.last     = 1'b1;
        end
        OP_TICK: begin
          if (pend_v_r) begin
            emit_v      = 1'b1;
            emit_w      = pend_r;
            emit_w.last = 1'b1;
          end else if (!stopped_r) begin
            emit_v      = 1'b1;
            emit_w.kind = KIND_NONE_DUE;
            emit_w.last = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_exp[wr_addr] <= wr_exp;
      mem_id[wr_addr]  <= wr_id;
      mem_act[wr_addr] <= wr_act;
      mem_arg[wr_addr] <= wr_arg;
    end
    if (cmd.rd_en) begin
      rd_exp_r <= mem_exp[rd_addr];
      rd_id_r  <= mem_id[rd_addr];
      rd_act_r <= mem_act[rd_addr];
      rd_arg_r <= mem_arg[rd_addr];
    end
  end

  // word payload, held fired entry, insert position, output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_in;
      now_r     <= in_word.current_time;
      exp_r     <= exp_in;
      act_r     <= in_word.action_code;
      arg_r     <= in_word.argument_handle;
      cid_r     <= in_word.cancel_id;
      id_new_r  <= id_sel;
      ovr_r     <= id_wrap;
      ins_pos_r <= count_r[IDXW-1:0];
    end
    if (cmd.proc && op_r == OP_INS && later) begin
      ins_pos_r <= dat_idx;
    end
    if (cmd.proc && op_r == OP_TICK && !stopped_r && due) begin
      pend_r <= {KIND_FIRED, rd_id_ext[TIMER_ID_W-1:0], rd_act_r, rd_arg_r, 1'b0, 1'b0};
    end
    out_word_r <= emit_w;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_id_r   <= '0;
      found_r     <= 1'b0;
      stopped_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_v;
      if (cmd.load) begin
        found_r   <= 1'b0;
        stopped_r <= 1'b0;
        pend_v_r  <= 1'b0;
        k_r       <= '0;
      end
      if (cmd.proc) begin
        case (op_r)
          OP_CANCEL: begin
            if (!found_r && id_hit) begin
              found_r <= 1'b1;
            end
          end
          OP_TICK: begin
            if (!stopped_r) begin
              if (due) begin
                pend_v_r <= 1'b1;
                k_r      <= k_r + CNTW'(1);
              end else begin
                stopped_r <= 1'b1;
                pend_v_r  <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        case (op_r)
          OP_INS: begin
            count_r   <= count_r + CNTW'(1);
            next_id_r <= id_new_r;
          end
          OP_CANCEL: begin
            if (found_r) begin
              count_r <= cnt_m1;
            end
          end
          OP_TICK: count_r <= count_r - k_r;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue: sorted timer table with schedule, cancel and tick
// One word occupies the block through load, setup, a walk of W entries
// (0 to DEPTH), one per cycle through the table memory's read port, and finish.
// Results leave in the cycle after they form; reset empties the table.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_macros.svh"

module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH   = STQ_DEPTH,
  parameter int ID_BITS = STQ_ID_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int IDXW = $clog2(DEPTH);

  stq_cmd_t        cmd;
  stq_sts_t        sts;
  logic [IDXW-1:0] first_idx;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] dat_idx;

  // sequencer
  stq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .first_idx (first_idx),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .dat_idx   (dat_idx)
  );

  // table and result logic
  stq_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .dat_idx   (dat_idx),
    .sts       (sts),
    .first_idx (first_idx),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // checks
  `STQ_ASSERT_NOW(a_out_from_work, !out_valid || $past(busy), "result word outside processing")
  `STQ_ASSERT_NEXT(a_load_busy, cmd.load, busy, "accepted word did not start processing")
  `STQ_ASSERT_NEXT(a_finish_idle, cmd.finish, !busy, "block still busy after finish")

endmodule
